/* hdl/frc_pkg.sv */
// Package with shared constants and types of the framed byte receiver.
package frc_pkg;

    // Default frame length in bytes, counting the end marker.
    localparam int FRAME_LEN_DEF = 5;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_END_MARKER = 2'd0;
    localparam t_cfg_idx CFG_ANGLE_MASK = 2'd1;
    localparam t_cfg_idx CFG_OMEGA_MASK = 2'd2;

    // Register values after reset.
    localparam logic [7:0] END_MARKER_RST = 8'd10;
    localparam logic [7:0] ANGLE_MASK_RST = 8'd1;
    localparam logic [7:0] OMEGA_MASK_RST = 8'd2;
    localparam logic [7:0] XOR_SEED       = 8'd1;

    // Scaling: floor(b*600/255) = floor(b*40/17). The division by 17 is a
    // multiplication by ceil(2^18/17), exact for products below 10201.
    localparam int         RECIP_SHIFT = 18;
    localparam logic [13:0] RECIP_17   = 14'd15421;

    typedef logic signed [10:0] t_tenths;

endpackage

/* hdl/frc_cell.sv */
// One byte cell of the frame shift line.
module frc_cell (
    input  logic       i_clk,
    input  logic       i_shift,
    input  logic [7:0] i_data,
    output logic [7:0] o_data
);

    logic [7:0] r_data;
    logic [7:0] n_data;

    always_comb begin
        n_data = i_shift ? i_data : r_data;
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

/* hdl/frc_scale.sv */
// Scales one byte to signed tenths, floor(b*600/255), with optional negation.
module frc_scale (
    input  logic            i_byte,
    input  logic [7:0]      i_value,
    input  logic            i_negate,
    output frc_pkg::t_tenths o_tenths
);

    logic [13:0] times40;
    logic [27:0] product;
    logic [9:0]  quotient;
    logic [10:0] magnitude;

    // The i_byte strobe only qualifies the result; idle inputs give zero.
    always_comb begin
        times40   = {1'b0, i_value, 5'b0} + {3'b0, i_value, 3'b0};
        product   = times40 * frc_pkg::RECIP_17;
        quotient  = product[frc_pkg::RECIP_SHIFT +: 10];
        magnitude = i_byte ? {1'b0, quotient} : 11'd0;
        o_tenths  = i_negate ? frc_pkg::t_tenths'(11'd0 - magnitude)
                             : frc_pkg::t_tenths'(magnitude);
    end

endmodule

/* hdl/xor_checked_frame_receiver_unit.sv */
// Top level of the end-marker framed receiver with XOR check byte.
// Throughput: one received byte item per cycle, back to back, while the
// capture stage can move on, else o_ready is low. A good frame is captured
// at its end marker, then passes the scaling multipliers into the output
// register. Reset (synchronous, active low) restores the registers to their
// defaults, empties the pipeline, zeroes the byte count and seeds the XOR.
module xor_checked_frame_receiver_unit #(
    parameter int FRAME_LEN = frc_pkg::FRAME_LEN_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // Received byte channel.
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic [7:0]              i_rx_byte,
    // Result channel.
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic [7:0]              o_status_byte,
    output frc_pkg::t_tenths        o_angle_tenths,
    output frc_pkg::t_tenths        o_omega_tenths,
    // Configuration write channel.
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  frc_pkg::t_cfg_idx       i_cfg_index,
    input  logic [7:0]              i_cfg_data
);

    // The frame is held in a shift line of FRAME_LEN-1 byte cells. Cell 0 holds
    // the newest byte, so once a full frame is in, cell 0 is the check byte and
    // the last cell is the status byte.
    localparam int STORE_LEN = FRAME_LEN - 1;
    localparam int CW        = $clog2(FRAME_LEN + 1);
    localparam logic [CW-1:0] CNT_STORE = CW'(STORE_LEN);
    localparam logic [CW-1:0] CNT_PAY   = CW'(STORE_LEN - 1);
    localparam logic [CW-1:0] CNT_MAX   = CW'(FRAME_LEN);

    // Configuration registers. Writes are always taken.
    logic [7:0] r_end_marker, n_end_marker;
    logic [7:0] r_angle_mask, n_angle_mask;
    logic [7:0] r_omega_mask, n_omega_mask;

    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_end_marker = r_end_marker;
        n_angle_mask = r_angle_mask;
        n_omega_mask = r_omega_mask;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                frc_pkg::CFG_END_MARKER: n_end_marker = i_cfg_data;
                frc_pkg::CFG_ANGLE_MASK: n_angle_mask = i_cfg_data;
                frc_pkg::CFG_OMEGA_MASK: n_omega_mask = i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_end_marker <= frc_pkg::END_MARKER_RST;
            r_angle_mask <= frc_pkg::ANGLE_MASK_RST;
            r_omega_mask <= frc_pkg::OMEGA_MASK_RST;
        end else begin
            r_end_marker <= n_end_marker;
            r_angle_mask <= n_angle_mask;
            r_omega_mask <= n_omega_mask;
        end
    end

    // Handshake and pipeline control. The capture stage moves on whenever the
    // output register is empty or its item is being taken.
    logic r_s1_valid, n_s1_valid;
    logic r_out_valid, n_out_valid;
    logic s1_adv;
    logic in_accept;
    logic is_marker;
    logic frame_ok;
    logic shift_en;

    assign s1_adv    = r_s1_valid && (!r_out_valid || i_ready);
    assign o_ready   = !r_s1_valid || s1_adv;
    assign in_accept = i_valid && o_ready;
    assign is_marker = (i_rx_byte == r_end_marker);

    // Byte count and running XOR.
    logic [CW-1:0] r_count, n_count;
    logic [7:0]    r_xor, n_xor;

    // The shift line only takes bytes while the frame is not yet full, so the
    // bytes past the check byte of an overlong frame are never stored.
    assign shift_en = in_accept && !is_marker && (r_count < CNT_STORE);

    logic [7:0] cell_q [STORE_LEN];

    genvar g;
    generate
        for (g = 0; g < STORE_LEN; g++) begin : g_cell
            if (g == 0) begin : g_head
                frc_cell u_cell (
                    .i_clk  (i_clk),
                    .i_shift(shift_en),
                    .i_data (i_rx_byte),
                    .o_data (cell_q[g])
                );
            end else begin : g_body
                frc_cell u_cell (
                    .i_clk  (i_clk),
                    .i_shift(shift_en),
                    .i_data (cell_q[g-1]),
                    .o_data (cell_q[g])
                );
            end
        end
    endgenerate

    assign frame_ok = (r_count == CNT_STORE) && (r_xor == cell_q[0]);

    always_comb begin
        n_count = r_count;
        n_xor   = r_xor;
        if (in_accept) begin
            if (is_marker) begin
                n_count = '0;
                n_xor   = frc_pkg::XOR_SEED;
            end else begin
                // Payload bytes fold into the XOR; the check byte does not.
                if (r_count < CNT_PAY) begin
                    n_xor = r_xor ^ i_rx_byte;
                end
                if (r_count < CNT_MAX) begin
                    n_count = r_count + CW'(1);
                end
            end
        end
    end

    // Capture stage: the three frame bytes and their sign decisions.
    logic [7:0] r_s1_status, r_s1_b1, r_s1_b2;
    logic       r_s1_neg_a, r_s1_neg_o;
    logic       capture;

    assign capture = in_accept && is_marker && frame_ok;

    always_comb begin
        n_s1_valid = r_s1_valid;
        if (capture) begin
            n_s1_valid = 1'b1;
        end else if (s1_adv) begin
            n_s1_valid = 1'b0;
        end
        n_out_valid = r_out_valid;
        if (s1_adv) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_xor       <= frc_pkg::XOR_SEED;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_xor       <= n_xor;
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (capture) begin
            r_s1_status <= cell_q[STORE_LEN-1];
            r_s1_b1     <= cell_q[STORE_LEN-2];
            r_s1_b2     <= cell_q[STORE_LEN-3];
            r_s1_neg_a  <= |(cell_q[STORE_LEN-1] & r_angle_mask);
            r_s1_neg_o  <= |(cell_q[STORE_LEN-1] & r_omega_mask);
        end
    end

    // Scaling stage: one multiplier per value, registered into the output.
    frc_pkg::t_tenths angle_d, omega_d;

    frc_scale u_scale_angle (
        .i_byte  (r_s1_valid),
        .i_value (r_s1_b1),
        .i_negate(r_s1_neg_a),
        .o_tenths(angle_d)
    );

    frc_scale u_scale_omega (
        .i_byte  (r_s1_valid),
        .i_value (r_s1_b2),
        .i_negate(r_s1_neg_o),
        .o_tenths(omega_d)
    );

    logic [7:0]       r_out_status;
    frc_pkg::t_tenths r_out_angle, r_out_omega;

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_status <= r_s1_status;
            r_out_angle  <= angle_d;
            r_out_omega  <= omega_d;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_status_byte  = r_out_status;
    assign o_angle_tenths = r_out_angle;
    assign o_omega_tenths = r_out_omega;

endmodule

/* bench/testbench.sv */
`timescale 1ns / 1ps
// Self-checking testbench of the end-marker framed receiver with its XOR check byte.
module testbench;

    localparam int FLEN        = frc_pkg::FRAME_LEN_DEF;
    // Bytes that must come before the end marker in a good frame.
    localparam int BODY_LEN    = FLEN - 1;
    localparam int DRAIN_WAIT  = 4;
    localparam int TAIL_WAIT   = 10;
    // Index that no register answers to; a write there must change nothing.
    localparam frc_pkg::t_cfg_idx CFG_UNUSED = 2'd3;

    typedef struct packed {
        logic [7:0]       status;
        frc_pkg::t_tenths angle;
        frc_pkg::t_tenths omega;
    } t_frame_result;

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_valid     = 1'b0;
    logic              o_ready;
    logic [7:0]        i_rx_byte   = 8'd0;
    logic              o_valid;
    logic              i_ready     = 1'b0;
    logic [7:0]        o_status_byte;
    frc_pkg::t_tenths  o_angle_tenths;
    frc_pkg::t_tenths  o_omega_tenths;
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    frc_pkg::t_cfg_idx i_cfg_index = frc_pkg::CFG_END_MARKER;
    logic [7:0]        i_cfg_data  = 8'd0;

    xor_checked_frame_receiver_unit i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_rx_byte      (i_rx_byte),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_status_byte  (o_status_byte),
        .o_angle_tenths (o_angle_tenths),
        .o_omega_tenths (o_omega_tenths),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    // Shadow copy of the registers and of the frame being collected.
    logic [7:0]    shadow_marker;
    logic [7:0]    shadow_angle_mask;
    logic [7:0]    shadow_omega_mask;
    logic [7:0]    rx_body [BODY_LEN];
    int unsigned   rx_count;
    logic [7:0]    rx_xor;
    t_frame_result pending_frames [$];

    int send_idle_pct = 0;
    int stall_pct     = 0;
    int hold_left     = 0;
    int err_count     = 0;
    int bytes_sent    = 0;
    int frames_seen   = 0;
    int cfg_writes    = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs on a handshake.
    initial begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

    // Scale a raw byte to tenths, floor(b*600/255), and negate it when asked.
    function automatic frc_pkg::t_tenths to_tenths(input logic [7:0] raw,
                                                   input logic negate);
        int v;
        v = int'(raw) * 600 / 255;
        if (negate) begin
            v = -v;
        end
        return frc_pkg::t_tenths'(v);
    endfunction

    task automatic clear_shadow();
        shadow_marker     = frc_pkg::END_MARKER_RST;
        shadow_angle_mask = frc_pkg::ANGLE_MASK_RST;
        shadow_omega_mask = frc_pkg::OMEGA_MASK_RST;
        foreach (rx_body[k]) begin
            rx_body[k] = 8'd0;
        end
        rx_count = 0;
        rx_xor   = frc_pkg::XOR_SEED;
    endtask

    // Advance the shadow frame state by one accepted byte. A marker closes the
    // frame and queues a result only for the right length and a matching check.
    task automatic track_byte(input logic [7:0] b);
        t_frame_result r;
        if (b == shadow_marker) begin
            if (rx_count == BODY_LEN && rx_xor == rx_body[BODY_LEN-1]) begin
                r.status = rx_body[0];
                r.angle  = to_tenths(rx_body[1], |(rx_body[0] & shadow_angle_mask));
                r.omega  = to_tenths(rx_body[2], |(rx_body[0] & shadow_omega_mask));
                pending_frames.push_back(r);
            end
            rx_count = 0;
            rx_xor   = frc_pkg::XOR_SEED;
        end else begin
            // The count saturates one past a good length, so an over-long
            // frame can never wrap around into looking good.
            if (rx_count < BODY_LEN) begin
                rx_body[rx_count] = b;
                if (rx_count < BODY_LEN - 1) begin
                    rx_xor ^= b;
                end
            end
            if (rx_count < FLEN) begin
                rx_count++;
            end
        end
    endtask

    // Offer one byte item, idling first at the current rate, and hold it
    // until the block takes it.
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_rx_byte <= b;
        do @(posedge i_clk); while (!o_ready);
        track_byte(b);
        bytes_sent++;
    endtask

    // Send a whole frame: status, angle, rate, any filler, check byte, marker.
    // A nonzero flip corrupts the check byte.
    task automatic send_frame(input logic [7:0] st, input logic [7:0] ang,
                              input logic [7:0] rate, input logic [7:0] flip);
        logic [7:0] body [BODY_LEN-1];
        logic [7:0] chk;
        body[0] = st;
        body[1] = ang;
        body[2] = rate;
        for (int k = 3; k < BODY_LEN - 1; k++) begin
            body[k] = 8'($urandom);
        end
        chk = frc_pkg::XOR_SEED;
        foreach (body[k]) begin
            chk ^= body[k];
            send_byte(body[k]);
        end
        send_byte(chk ^ flip);
        send_byte(shadow_marker);
    endtask

    // Bytes that never equal the marker, so they only lengthen the frame.
    task automatic send_filler(input int n);
        logic [7:0] b;
        repeat (n) begin
            b = 8'($urandom);
            if (b == shadow_marker) begin
                b ^= 8'h01;
            end
            send_byte(b);
        end
    endtask

    // Stop offering bytes and wait until every expected result is out, then wait
    // out the DRAIN_WAIT margin.
    task automatic drain();
        i_valid <= 1'b0;
        while (pending_frames.size() > 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    // One register write. The valid stays high so writes can go back to back.
    task automatic write_reg(input frc_pkg::t_cfg_idx idx, input logic [7:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            frc_pkg::CFG_END_MARKER: shadow_marker     = data;
            frc_pkg::CFG_ANGLE_MASK: shadow_angle_mask = data;
            frc_pkg::CFG_OMEGA_MASK: shadow_omega_mask = data;
            default: ;
        endcase
        cfg_writes++;
    endtask

    task automatic apply_settings(input logic [7:0] marker, input logic [7:0] amask,
                                  input logic [7:0] omask);
        drain();
        write_reg(frc_pkg::CFG_END_MARKER, marker);
        write_reg(CFG_UNUSED, 8'($urandom));
        write_reg(frc_pkg::CFG_ANGLE_MASK, amask);
        write_reg(frc_pkg::CFG_OMEGA_MASK, omask);
        i_cfg_valid <= 1'b0;
    endtask

    // Mostly well-formed frames with random content; the rest have a bad
    // check byte, the wrong length, or stray bytes that spill into the next.
    task automatic run_frames(input int count);
        int roll;
        repeat (count) begin
            roll = $urandom_range(99);
            if (roll < 75) begin
                send_frame(8'($urandom), 8'($urandom), 8'($urandom), 8'd0);
            end else if (roll < 85) begin
                send_frame(8'($urandom), 8'($urandom), 8'($urandom),
                           8'(1 << $urandom_range(7)));
            end else if (roll < 93) begin
                send_filler($urandom_range(0, FLEN + 3));
                send_byte(shadow_marker);
            end else begin
                send_filler($urandom_range(1, 5));
            end
        end
    endtask

    // Default registers: scaling extremes, both sign masks, negative zero,
    // bad check, short frame and a lone marker.
    task automatic test_directed();
        send_idle_pct = 0;
        stall_pct     = 0;
        send_frame(8'h00, 8'd255, 8'd0, 8'd0);
        send_frame(8'h03, 8'd255, 8'd255, 8'd0);
        send_frame(8'h01, 8'd0, 8'd128, 8'd0);
        send_frame(8'h02, 8'h40, 8'h11, 8'h80);
        send_byte(8'h55);
        send_byte(shadow_marker);
        send_byte(shadow_marker);
    endtask

    // Over-long frames whose last bytes form a good frame; the saturating
    // count must still reject them.
    task automatic test_overrun();
        for (int n = 1; n <= 20; n += 3) begin
            send_filler(n);
            send_frame(8'($urandom), 8'($urandom), 8'($urandom), 8'd0);
        end
        send_frame(8'($urandom), 8'($urandom), 8'($urandom), 8'd0);
    endtask

    // Register settings with their extremes, each run through every idle mix.
    task automatic test_settings();
        logic [7:0] markers [6];
        logic [7:0] amasks  [6];
        logic [7:0] omasks  [6];
        int         send_pcts  [4];
        int         stall_pcts [4];
        markers    = '{8'd0, 8'd255, 8'h7E, 8'd10, 8'd0, 8'd0};
        amasks     = '{8'hFF, 8'h00, 8'h80, 8'h01, 8'd0, 8'd0};
        omasks     = '{8'h00, 8'hFF, 8'h81, 8'h02, 8'd0, 8'd0};
        send_pcts  = '{0, 63, 0, 36};
        stall_pcts = '{0, 0, 63, 36};
        for (int s = 4; s < 6; s++) begin
            markers[s] = 8'($urandom);
            amasks[s]  = 8'($urandom);
            omasks[s]  = 8'($urandom);
        end
        foreach (markers[s]) begin
            apply_settings(markers[s], amasks[s], omasks[s]);
            foreach (send_pcts[p]) begin
                send_idle_pct = send_pcts[p];
                stall_pct     = stall_pcts[p];
                run_frames(14);
            end
        end
    endtask

    // The receiver holds off for a long stretch while good frames keep
    // coming, so the result path fills up and the input has to stall.
    task automatic test_backpressure();
        send_idle_pct = 0;
        stall_pct     = 36;
        hold_left     = 200;
        repeat (40) begin
            send_frame(8'($urandom), 8'($urandom), 8'($urandom), 8'd0);
        end
    endtask

    // Result side ready: a counted hold-off when one is asked for, otherwise
    // random stalls at the current rate.
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            i_ready   <= 1'b0;
            hold_left = hold_left - 1;
        end else begin
            i_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Every accepted result item is checked against the oldest expected frame.
    always @(posedge i_clk) begin : result_check
        t_frame_result want;
        if (i_rst_n && o_valid && i_ready) begin
            frames_seen++;
            if (pending_frames.size() == 0) begin
                $display("%0t: unexpected result, expected none, %s %h angle %0d omega %0d",
                         $time, "got status", o_status_byte, o_angle_tenths,
                         o_omega_tenths);
                err_count++;
            end else begin
                want = pending_frames.pop_front();
                if (o_status_byte !== want.status) begin
                    $display("%0t: status_byte expected %h, got %h",
                             $time, want.status, o_status_byte);
                    err_count++;
                end
                if (o_angle_tenths !== want.angle) begin
                    $display("%0t: angle_tenths expected %0d, got %0d",
                             $time, want.angle, o_angle_tenths);
                    err_count++;
                end
                if (o_omega_tenths !== want.omega) begin
                    $display("%0t: omega_tenths expected %0d, got %0d",
                             $time, want.omega, o_omega_tenths);
                    err_count++;
                end
            end
        end
    end

    initial begin
        clear_shadow();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_overrun();
        test_settings();
        test_backpressure();

        drain();
        repeat (TAIL_WAIT) @(posedge i_clk);
        $display("Sent %0d byte items and %0d register writes; checked %0d frame results.",
                 bytes_sent, cfg_writes, frames_seen);
        $display("Covered defaults, marker and mask extremes, bad and over-long frames, %s",
                 "idle and stall mixes, and a long result hold-off.");
        if (err_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
